[rtl/core/sha512_crypt_string_validator_unit_macros.svh]
// Assertion macros for the validator RTL, used by scsv_parser.
`ifndef SHA512_CRYPT_STRING_VALIDATOR_UNIT_MACROS_SVH
`define SHA512_CRYPT_STRING_VALIDATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SCSV_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("scsv assertion failed");
`define SCSV_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("scsv assertion failed");
`else
`define SCSV_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define SCSV_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

[rtl/core/scsv_pkg.sv]
package scsv_pkg;

    localparam int CHAR_W  = 8;
    localparam int POS_W   = 7;
    localparam int LIT_W   = 3;
    localparam int ROUND_W = 20;
    localparam int SALT_W  = 5;
    localparam int DIG_W   = 7;
    localparam int PROD_W  = 24;

    localparam logic [POS_W-1:0]   MAX_STRING_LEN = 7'd123;
    localparam logic [POS_W-1:0]   BYTE_COUNT_TOP = 7'd127;
    localparam logic [DIG_W-1:0]   DIGEST_CHARS   = 7'd86;
    localparam logic [SALT_W-1:0]  MAX_SALT_CHARS = 5'd16;
    localparam logic [ROUND_W-1:0] ROUNDS_MIN     = 20'd1000;
    localparam logic [PROD_W-1:0]  ROUNDS_MAX     = 24'd1000000;
    localparam logic [ROUND_W-1:0] ROUNDS_DEFAULT = 20'd5000;
    localparam logic [LIT_W-1:0]   PREFIX_LEN     = 3'd3;
    localparam logic [LIT_W-1:0]   KEYWORD_LEN    = 3'd7;

    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_KEYWORD,
        PH_DIGITS,
        PH_SALT,
        PH_DIGEST
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              need_digest;
    } char_req_t;

    typedef struct packed {
        logic               valid_res;
        logic [ROUND_W-1:0] round_count;
        logic               rounds_given;
        logic [SALT_W-1:0]  salt_start;
        logic [SALT_W-1:0]  salt_len;
    } verdict_t;

    typedef struct packed {
        logic     held_valid;
        logic     out_space;
    } flow_t;

    function automatic logic [CHAR_W-1:0] prefix_char(input logic [LIT_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        unique case (idx)
            3'd1:    ch = 8'h36;
            default: ch = CH_DOLLAR;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] keyword_char(input logic [LIT_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h72;
            3'd1:    ch = 8'h6f;
            3'd2:    ch = 8'h75;
            3'd3:    ch = 8'h6e;
            3'd4:    ch = 8'h64;
            3'd5:    ch = 8'h73;
            default: ch = 8'h3d;
        endcase
        return ch;
    endfunction

    function automatic logic salt_char_ok(input logic [CHAR_W-1:0] c);
        logic ok;
        ok = (c >= 8'h21) && (c <= 8'h7e) && (c != CH_DOLLAR) && (c != 8'h3a)
            && (c != 8'h3b) && (c != 8'h2a) && (c != 8'h21) && (c != 8'h5c);
        return ok;
    endfunction

    function automatic logic digest_char_ok(input logic [CHAR_W-1:0] c);
        logic ok;
        ok = ((c >= CH_ZERO) && (c <= CH_NINE)) || ((c >= 8'h41) && (c <= 8'h5a))
            || ((c >= 8'h61) && (c <= 8'h7a)) || (c == 8'h2e) || (c == 8'h2f);
        return ok;
    endfunction

endpackage

[rtl/core/scsv_char_if.sv]
interface scsv_char_if
    import scsv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              need_digest;

    modport source (output valid, output char_byte, output need_digest, input ready);
    modport sink (input valid, input char_byte, input need_digest, output ready);
endinterface

[rtl/core/scsv_verdict_if.sv]
interface scsv_verdict_if
    import scsv_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [ROUND_W-1:0] round_count;
    logic               rounds_given;
    logic [SALT_W-1:0]  salt_start;
    logic [SALT_W-1:0]  salt_len;

    modport source (output valid, output valid_res, output round_count,
        output rounds_given, output salt_start, output salt_len, input ready);
    modport sink (input valid, input valid_res, input round_count,
        input rounds_given, input salt_start, input salt_len, output ready);
endinterface

[rtl/core/sha512_crypt_string_validator_unit.sv]
// Channel       Dir  Payload                                             Accept
// char_chan     in   char_byte[7:0], need_digest                         valid & ready
// verdict_chan  out  valid_res, round_count[19:0], rounds_given,         valid & ready
//                    salt_start[4:0], salt_len[4:0]
// One byte is taken per cycle unless a zero byte waits for the output; each passes the
// input register, then the parser state update; a zero byte loads the verdict register.
// Nonzero bytes never wait on the output side; a zero byte waits in the input register
// while an earlier verdict is still held, and ready then follows verdict_chan.ready.
// rst_n clears the parser state and both valid flags; the first byte may follow at once.
module sha512_crypt_string_validator_unit
    import scsv_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    scsv_char_if.sink    char_chan,
    scsv_verdict_if.source verdict_chan
);

    char_req_t in_req;
    char_req_t held_req;
    logic      held_valid;
    logic      take;
    logic      res_valid;
    logic      out_space;
    logic      out_valid;
    verdict_t  res;
    verdict_t  out_res;
    flow_t     flow;

    assign in_req.char_byte   = char_chan.char_byte;
    assign in_req.need_digest = char_chan.need_digest;

    assign flow.held_valid = held_valid;
    assign flow.out_space  = out_space;

    scsv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (char_chan.valid),
        .in_ready   (char_chan.ready),
        .in_req     (in_req),
        .take       (take),
        .held_valid (held_valid),
        .held_req   (held_req)
    );

    scsv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .held_req  (held_req),
        .flow_in   (flow),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    scsv_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (verdict_chan.ready),
        .out_valid (out_valid),
        .out_space (out_space),
        .out_res   (out_res)
    );

    assign verdict_chan.valid        = out_valid;
    assign verdict_chan.valid_res    = out_res.valid_res;
    assign verdict_chan.round_count  = out_res.round_count;
    assign verdict_chan.rounds_given = out_res.rounds_given;
    assign verdict_chan.salt_start   = out_res.salt_start;
    assign verdict_chan.salt_len     = out_res.salt_len;

endmodule

[rtl/core/scsv_in_stage.sv]
module scsv_in_stage
    import scsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  char_req_t in_req,
    input  logic      take,
    output logic      held_valid,
    output char_req_t held_req
);

    logic      valid_reg;
    logic      valid_next;
    char_req_t req_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_req   = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

endmodule

[rtl/core/scsv_parser.sv]
`include "sha512_crypt_string_validator_unit_macros.svh"

module scsv_parser
    import scsv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  char_req_t held_req,
    input  flow_t     flow_in,
    output logic      take,
    output logic      res_valid,
    output verdict_t  res
);

    phase_t             phase_reg,        phase_next;
    logic [POS_W-1:0]   byte_count_reg,   byte_count_next;
    logic [LIT_W-1:0]   literal_index_reg, literal_index_next;
    logic [ROUND_W-1:0] round_accum_reg,  round_accum_next;
    logic               rounds_seen_reg,  rounds_seen_next;
    logic [SALT_W-1:0]  salt_begin_reg,   salt_begin_next;
    logic [SALT_W-1:0]  salt_count_reg,   salt_count_next;
    logic [DIG_W-1:0]   digest_count_reg, digest_count_next;
    logic               failed_reg,       failed_next;
    logic               digest_mode_reg,  digest_mode_next;

    logic [CHAR_W-1:0]  c;
    logic               is_end;
    logic               mode_eff;
    logic               fail_pre;
    logic [SALT_W-1:0]  sc_in;
    logic [SALT_W-1:0]  sc_out;
    logic               s_fail;
    logic               s_digest;
    logic [PROD_W-1:0]  acc_wide;
    logic [PROD_W-1:0]  acc_prod;
    logic               ok;
    logic [POS_W-1:0]   pos_inc;

    assign c        = held_req.char_byte;
    assign is_end   = (c == CH_NUL);
    assign take     = flow_in.held_valid && (!is_end || flow_in.out_space);
    assign mode_eff = (byte_count_reg == '0) ? held_req.need_digest : digest_mode_reg;
    assign fail_pre = failed_reg || (byte_count_reg >= MAX_STRING_LEN);
    assign sc_in    = (phase_reg == PH_KEYWORD) ? {{(SALT_W-LIT_W){1'b0}}, literal_index_reg}
                                                : salt_count_reg;
    assign acc_wide = {{(PROD_W-ROUND_W){1'b0}}, round_accum_reg};
    assign acc_prod = (acc_wide << 3) + (acc_wide << 1)
                    + {{(PROD_W-4){1'b0}}, c[3:0]};
    assign pos_inc  = byte_count_reg + 7'd1;

    always_comb
    begin
        sc_out   = sc_in;
        s_fail   = 1'b0;
        s_digest = 1'b0;
        if (salt_char_ok(c))
        begin
            if (sc_in <= MAX_SALT_CHARS)
            begin
                sc_out = sc_in + 5'd1;
            end
            s_fail = (sc_out > MAX_SALT_CHARS);
        end
        else if ((sc_in >= 5'd1) && (sc_in <= MAX_SALT_CHARS) && mode_eff
            && (c == CH_DOLLAR))
        begin
            s_digest = 1'b1;
        end
        else
        begin
            s_fail = 1'b1;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        literal_index_next = literal_index_reg;
        round_accum_next   = round_accum_reg;
        rounds_seen_next   = rounds_seen_reg;
        salt_begin_next    = salt_begin_reg;
        salt_count_next    = salt_count_reg;
        digest_count_next  = digest_count_reg;
        failed_next        = failed_reg;
        digest_mode_next   = digest_mode_reg;
        res_valid          = 1'b0;
        res                = '0;
        ok                 = 1'b0;
        if (take && is_end)
        begin
            unique case (phase_reg)
                PH_KEYWORD, PH_SALT:
                    ok = !failed_reg && (sc_in >= 5'd1) && (sc_in <= MAX_SALT_CHARS)
                        && !digest_mode_reg;
                PH_DIGEST:
                    ok = !failed_reg && (digest_count_reg == DIGEST_CHARS);
                default:
                    ok = 1'b0;
            endcase
            res_valid = 1'b1;
            if (ok)
            begin
                res.valid_res    = 1'b1;
                res.round_count  = rounds_seen_reg ? round_accum_reg : ROUNDS_DEFAULT;
                res.rounds_given = rounds_seen_reg;
                res.salt_start   = salt_begin_reg;
                res.salt_len     = sc_in;
            end
            phase_next         = PH_PREFIX;
            byte_count_next    = '0;
            literal_index_next = '0;
            round_accum_next   = '0;
            rounds_seen_next   = 1'b0;
            salt_begin_next    = '0;
            salt_count_next    = '0;
            digest_count_next  = '0;
            failed_next        = 1'b0;
            digest_mode_next   = 1'b0;
        end
        else if (take)
        begin
            digest_mode_next = mode_eff;
            if (byte_count_reg < BYTE_COUNT_TOP)
            begin
                byte_count_next = pos_inc;
            end
            failed_next = fail_pre;
            if (!fail_pre)
            begin
                unique case (phase_reg)
                    PH_PREFIX:
                    begin
                        if ((literal_index_reg >= PREFIX_LEN)
                            || (c != prefix_char(literal_index_reg)))
                        begin
                            failed_next = 1'b1;
                        end
                        else if (literal_index_reg == PREFIX_LEN - 3'd1)
                        begin
                            phase_next         = PH_KEYWORD;
                            literal_index_next = '0;
                            salt_begin_next    = {{(SALT_W-LIT_W){1'b0}}, PREFIX_LEN};
                        end
                        else
                        begin
                            literal_index_next = literal_index_reg + 3'd1;
                        end
                    end
                    PH_KEYWORD:
                    begin
                        if ((literal_index_reg < KEYWORD_LEN)
                            && (c == keyword_char(literal_index_reg)))
                        begin
                            literal_index_next = literal_index_reg + 3'd1;
                            if (literal_index_reg == KEYWORD_LEN - 3'd1)
                            begin
                                phase_next       = PH_DIGITS;
                                round_accum_next = '0;
                            end
                        end
                        else
                        begin
                            salt_count_next = sc_out;
                            failed_next     = s_fail;
                            phase_next      = s_digest ? PH_DIGEST : PH_SALT;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if ((c >= CH_ZERO) && (c <= CH_NINE))
                        begin
                            if (((round_accum_reg == '0) && (c == CH_ZERO))
                                || (acc_prod > ROUNDS_MAX))
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                round_accum_next = acc_prod[ROUND_W-1:0];
                            end
                        end
                        else if ((c == CH_DOLLAR) && (round_accum_reg >= ROUNDS_MIN))
                        begin
                            rounds_seen_next = 1'b1;
                            salt_begin_next  = pos_inc[SALT_W-1:0];
                            salt_count_next  = '0;
                            phase_next       = PH_SALT;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_SALT:
                    begin
                        salt_count_next = sc_out;
                        failed_next     = s_fail;
                        if (s_digest)
                        begin
                            phase_next = PH_DIGEST;
                        end
                    end
                    PH_DIGEST:
                    begin
                        if (!digest_char_ok(c))
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            if (digest_count_reg <= DIGEST_CHARS)
                            begin
                                digest_count_next = digest_count_reg + 7'd1;
                            end
                            failed_next = (digest_count_next > DIGEST_CHARS);
                        end
                    end
                    default:
                        failed_next = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_PREFIX;
            byte_count_reg    <= '0;
            literal_index_reg <= '0;
            round_accum_reg   <= '0;
            rounds_seen_reg   <= 1'b0;
            salt_begin_reg    <= '0;
            salt_count_reg    <= '0;
            digest_count_reg  <= '0;
            failed_reg        <= 1'b0;
            digest_mode_reg   <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            literal_index_reg <= literal_index_next;
            round_accum_reg   <= round_accum_next;
            rounds_seen_reg   <= rounds_seen_next;
            salt_begin_reg    <= salt_begin_next;
            salt_count_reg    <= salt_count_next;
            digest_count_reg  <= digest_count_next;
            failed_reg        <= failed_next;
            digest_mode_reg   <= digest_mode_next;
        end
    end

    `SCSV_ASSERT_NEXT(a_fail_sticky, clk, rst_n, failed_reg && take && !is_end, failed_reg)
    `SCSV_ASSERT_NEXT(a_end_clears, clk, rst_n, take && is_end, (phase_reg == PH_PREFIX) && (byte_count_reg == '0) && !failed_reg)
    `SCSV_ASSERT_SAME(a_good_fields, clk, rst_n, res_valid && res.valid_res, (res.round_count >= ROUNDS_MIN) && (res.salt_len >= 5'd1) && (res.salt_len <= MAX_SALT_CHARS))
    `SCSV_ASSERT_SAME(a_end_needs_room, clk, rst_n, res_valid, flow_in.out_space && flow_in.held_valid)

endmodule

[rtl/core/scsv_out_stage.sv]
module scsv_out_stage
    import scsv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     res_valid,
    input  verdict_t res,
    input  logic     out_ready,
    output logic     out_valid,
    output logic     out_space,
    output verdict_t out_res
);

    logic     valid_reg;
    logic     valid_next;
    verdict_t res_reg;

    assign out_valid = valid_reg;
    assign out_space = !valid_reg || out_ready;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import scsv_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_STALL = 400;
    localparam string CRYPT_PREFIX = "$6$";
    localparam string ROUNDS_KEY = "rounds=";
    localparam string B64_SET =
        "./0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    logic clk = 1'b0;
    logic rst_n;

    scsv_char_if char_chan ();
    scsv_verdict_if verdict_chan ();

    sha512_crypt_string_validator_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_chan    (char_chan),
        .verdict_chan (verdict_chan)
    );

    char_req_t char_q[$];
    verdict_t verdict_q[$];

    int unsigned src_idle_pct = 0;
    int unsigned dst_stall_pct = 0;
    bit long_stall_go = 1'b0;
    int unsigned mismatches = 0;
    int unsigned bytes_queued = 0;
    int unsigned strings_queued = 0;
    int unsigned cycle_cnt = 0;

    phase_t st_phase;
    logic [POS_W-1:0] st_pos;
    logic [LIT_W-1:0] st_lit;
    logic [ROUND_W-1:0] st_rounds;
    logic st_has_rounds;
    logic [SALT_W-1:0] st_salt_at;
    logic [SALT_W-1:0] st_salt_n;
    logic [DIG_W-1:0] st_dig_n;
    logic st_bad;
    logic st_dig_mode;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void clear_parser();
        st_phase = PH_PREFIX;
        st_pos = '0;
        st_lit = '0;
        st_rounds = '0;
        st_has_rounds = 1'b0;
        st_salt_at = '0;
        st_salt_n = '0;
        st_dig_n = '0;
        st_bad = 1'b0;
        st_dig_mode = 1'b0;
    endfunction

    function automatic bit is_salt_char(input logic [7:0] c);
        case (c)
            "$", ":", ";", "*", "!", "\\": return 1'b0;
            default: return (c >= 8'h21) && (c <= 8'h7e);
        endcase
    endfunction

    function automatic bit is_b64_char(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (c == B64_SET[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void salt_take(input logic [7:0] c);
        if (is_salt_char(c))
        begin
            if (st_salt_n <= MAX_SALT_CHARS)
                st_salt_n++;
            if (st_salt_n > MAX_SALT_CHARS)
                st_bad = 1'b1;
        end
        else if (st_salt_n == 0 || st_salt_n > MAX_SALT_CHARS || !st_dig_mode
                 || c != CH_DOLLAR)
            st_bad = 1'b1;
        else
            st_phase = PH_DIGEST;
    endfunction

    function automatic bit parse_char(input char_req_t req, output verdict_t v);
        logic [7:0] c;
        logic [POS_W-1:0] at;
        int unsigned nxt;
        bit ok;
        c = req.char_byte;
        at = st_pos;
        v = '0;
        if (c == CH_NUL)
        begin
            ok = !st_bad;
            if (st_phase == PH_KEYWORD)
                st_salt_n = SALT_W'(st_lit);
            if (st_phase == PH_KEYWORD || st_phase == PH_SALT)
                ok = ok && st_salt_n >= 1 && st_salt_n <= MAX_SALT_CHARS && !st_dig_mode;
            else if (st_phase == PH_DIGEST)
                ok = ok && st_dig_n == DIGEST_CHARS;
            else
                ok = 1'b0;
            if (ok)
            begin
                v.valid_res = 1'b1;
                v.round_count = st_has_rounds ? st_rounds : ROUNDS_DEFAULT;
                v.rounds_given = st_has_rounds;
                v.salt_start = st_salt_at;
                v.salt_len = st_salt_n;
            end
            clear_parser();
            return 1'b1;
        end
        if (at == 0)
            st_dig_mode = req.need_digest;
        if (st_pos < BYTE_COUNT_TOP)
            st_pos++;
        if (at >= MAX_STRING_LEN)
            st_bad = 1'b1;
        if (st_bad)
            return 1'b0;
        case (st_phase)
            PH_PREFIX:
            begin
                if (c != CRYPT_PREFIX[st_lit])
                    st_bad = 1'b1;
                else if (st_lit == PREFIX_LEN - 1)
                begin
                    st_phase = PH_KEYWORD;
                    st_lit = '0;
                    st_salt_at = SALT_W'(PREFIX_LEN);
                end
                else
                    st_lit++;
            end
            PH_KEYWORD:
            begin
                if (st_lit < KEYWORD_LEN && c == ROUNDS_KEY[st_lit])
                begin
                    st_lit++;
                    if (st_lit == KEYWORD_LEN)
                    begin
                        st_phase = PH_DIGITS;
                        st_rounds = '0;
                    end
                end
                else
                begin
                    st_salt_n = SALT_W'(st_lit);
                    st_phase = PH_SALT;
                    salt_take(c);
                end
            end
            PH_DIGITS:
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    nxt = 32'(st_rounds) * 10 + 32'(c - CH_ZERO);
                    if ((st_rounds == 0 && c == CH_ZERO) || nxt > ROUNDS_MAX)
                        st_bad = 1'b1;
                    else
                        st_rounds = ROUND_W'(nxt);
                end
                else if (c == CH_DOLLAR && st_rounds >= ROUNDS_MIN)
                begin
                    st_has_rounds = 1'b1;
                    st_salt_at = SALT_W'(at + 1);
                    st_salt_n = '0;
                    st_phase = PH_SALT;
                end
                else
                    st_bad = 1'b1;
            end
            PH_SALT: salt_take(c);
            PH_DIGEST:
            begin
                if (!is_b64_char(c))
                    st_bad = 1'b1;
                else
                begin
                    if (st_dig_n <= DIGEST_CHARS)
                        st_dig_n++;
                    if (st_dig_n > DIGEST_CHARS)
                        st_bad = 1'b1;
                end
            end
            default: st_bad = 1'b1;
        endcase
        return 1'b0;
    endfunction

    function automatic void cmp_field(input string tag, input logic [ROUND_W-1:0] want,
                                      input logic [ROUND_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, tag, want, got);
            mismatches++;
        end
    endfunction

    function automatic void queue_bytes(input byte unsigned s[$], input bit mode);
        char_req_t req;
        foreach (s[i])
        begin
            req.char_byte = s[i];
            req.need_digest = (i == 0) ? mode : 1'($urandom_range(1));
            char_q.push_back(req);
        end
        req.char_byte = CH_NUL;
        req.need_digest = (s.size() == 0) ? mode : 1'($urandom_range(1));
        char_q.push_back(req);
        bytes_queued += s.size() + 1;
        strings_queued++;
    endfunction

    function automatic void queue_text(input string t, input bit mode);
        byte unsigned s[$];
        for (int i = 0; i < t.len(); i++)
            s.push_back(t.getc(i));
        queue_bytes(s, mode);
    endfunction

    function automatic byte unsigned salt_char();
        byte unsigned c;
        do
            c = $urandom_range(8'h21, 8'h7e);
        while (!is_salt_char(c));
        return c;
    endfunction

    function automatic void queue_crypt_string(input bit want_digest);
        byte unsigned s[$];
        int unsigned roll, n, k;
        string num;
        bit mode;
        roll = $urandom_range(99);
        for (int i = 0; i < 3; i++)
            s.push_back(CRYPT_PREFIX[i]);
        if ($urandom_range(1))
        begin
            for (int i = 0; i < 7; i++)
                s.push_back(ROUNDS_KEY[i]);
            case ($urandom_range(9))
                0: n = 1000;
                1: n = 1000000;
                2: n = $urandom_range(1, 999);
                3: n = $urandom_range(1000001, 9999999);
                default: n = $urandom_range(1000, 1000000);
            endcase
            num = $sformatf("%0d", n);
            if ($urandom_range(19) == 0)
                num = {"0", num};
            for (int i = 0; i < num.len(); i++)
                s.push_back(num.getc(i));
            s.push_back("$");
        end
        else if ($urandom_range(4) == 0)
        begin
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++)
                s.push_back(ROUNDS_KEY[i]);
        end
        case ($urandom_range(19))
            0: k = 0;
            1: k = MAX_SALT_CHARS + 1;
            2, 3: k = MAX_SALT_CHARS;
            default: k = $urandom_range(1, MAX_SALT_CHARS);
        endcase
        repeat (k) s.push_back(salt_char());
        if (want_digest)
        begin
            s.push_back("$");
            case ($urandom_range(9))
                0: k = DIGEST_CHARS - 1;
                1: k = DIGEST_CHARS + 1;
                default: k = DIGEST_CHARS;
            endcase
            repeat (k) s.push_back(B64_SET[$urandom_range(63)]);
        end
        if (roll < 10)
            s[$urandom_range(s.size() - 1)] = $urandom_range(1, 255);
        else if (roll < 15)
        begin
            k = $urandom_range(s.size() - 1);
            while (s.size() > k)
                void'(s.pop_back());
        end
        else if (roll < 18)
        begin
            k = $urandom_range(124, 135);
            while (s.size() < k)
                s.push_back(B64_SET[$urandom_range(63)]);
        end
        mode = want_digest ^ ($urandom_range(9) == 0);
        queue_bytes(s, mode);
    endfunction

    function automatic void queue_noise();
        byte unsigned s[$];
        int unsigned k;
        k = ($urandom_range(29) == 0) ? $urandom_range(124, 140) : $urandom_range(0, 20);
        repeat (k) s.push_back($urandom_range(1, 255));
        queue_bytes(s, 1'($urandom_range(1)));
    endfunction

    function automatic void fill_phase(input int unsigned byte_goal);
        int unsigned start_bytes, start_strings, pick;
        start_bytes = bytes_queued;
        start_strings = strings_queued;
        while (bytes_queued - start_bytes < byte_goal || strings_queued - start_strings < 15)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_crypt_string(1'b0);
            else if (pick < 80)
                queue_crypt_string(1'b1);
            else
                queue_noise();
        end
    endfunction

    task automatic wait_drained();
        while (char_q.size() != 0 || char_chan.valid || verdict_q.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        char_req_t nxt_req;
        if (!rst_n)
        begin
            char_chan.valid <= 1'b0;
            char_chan.char_byte <= '0;
            char_chan.need_digest <= 1'b0;
        end
        else if (!char_chan.valid || char_chan.ready)
        begin
            if (char_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                nxt_req = char_q.pop_front();
                char_chan.valid <= 1'b1;
                char_chan.char_byte <= nxt_req.char_byte;
                char_chan.need_digest <= nxt_req.need_digest;
            end
            else
                char_chan.valid <= 1'b0;
        end
    end

    int unsigned stall_left;
    bit stall_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_chan.ready <= 1'b0;
            stall_left <= 0;
            stall_done <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            verdict_chan.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (long_stall_go && !stall_done)
        begin
            verdict_chan.ready <= 1'b0;
            stall_left <= LONG_STALL;
            stall_done <= 1'b1;
        end
        else
            verdict_chan.ready <= ($urandom_range(99) >= dst_stall_pct);
    end

    always @(posedge clk)
    begin : watch_channels
        verdict_t want, got;
        char_req_t in_req;
        if (rst_n)
        begin
            if (verdict_chan.valid && verdict_chan.ready)
            begin
                got.valid_res = verdict_chan.valid_res;
                got.round_count = verdict_chan.round_count;
                got.rounds_given = verdict_chan.rounds_given;
                got.salt_start = verdict_chan.salt_start;
                got.salt_len = verdict_chan.salt_len;
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected verdict, expected none, got %p", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    cmp_field("valid_res", want.valid_res, got.valid_res);
                    cmp_field("round_count", want.round_count, got.round_count);
                    cmp_field("rounds_given", want.rounds_given, got.rounds_given);
                    cmp_field("salt_start", want.salt_start, got.salt_start);
                    cmp_field("salt_len", want.salt_len, got.salt_len);
                end
            end
            if (char_chan.valid && char_chan.ready)
            begin
                in_req.char_byte = char_chan.char_byte;
                in_req.need_digest = char_chan.need_digest;
                if (parse_char(in_req, want))
                    verdict_q.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : run_phases
        int unsigned idle_src[4] = '{0, 56, 0, 14};
        int unsigned idle_dst[4] = '{0, 0, 56, 14};
        char_chan.valid = 1'b0;
        char_chan.char_byte = '0;
        char_chan.need_digest = 1'b0;
        verdict_chan.ready = 1'b0;
        rst_n = 1'b0;
        clear_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_text("", 1'b1);
        queue_text("$6$", 1'b0);
        queue_text("$6$rounds", 1'b0);
        queue_text("$6$roun$", 1'b1);
        queue_text("$6$rounds=1000$s", 1'b0);
        queue_text("$6$rounds=1000000$./", 1'b0);
        queue_text("$6$rounds=1000001$s", 1'b0);
        queue_text("$6$rounds=0", 1'b0);
        queue_text("$6$rounds=999$s", 1'b0);
        queue_text("$6$0123456789abcdef", 1'b0);
        queue_text("$6$0123456789abcdefg", 1'b0);
        queue_text("$6$a:b", 1'b0);
        queue_text("$6$ab$", 1'b0);
        queue_text("$7$x", 1'b0);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = idle_src[p];
            dst_stall_pct = idle_dst[p];
            if (p == 0)
                long_stall_go = 1'b1;
            fill_phase(475);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
